// File: hw/rtl/pidl_pkg.sv
`timescale 1ns / 1ps
// pidl_pkg: sizes, operation and status codes and the cell control type
// for the positional insert/delete list
// no dependencies

package pidl_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned IDX_W  = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] value;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/pidl_req_if.sv
`timescale 1ns / 1ps
// pidl_req_if: request channel of the list, valid/ready with operation payload
// depends on pidl_pkg

interface pidl_req_if;
  import pidl_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [POS_W-1:0]  position;
  logic [ELEM_W-1:0] write_value;

  modport source (output valid, action, position, write_value, input ready);
  modport sink   (input valid, action, position, write_value, output ready);
endinterface

// File: hw/rtl/pidl_rsp_if.sv
`timescale 1ns / 1ps
// pidl_rsp_if: response channel of the list, valid/ready with result payload
// depends on pidl_pkg

interface pidl_rsp_if;
  import pidl_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ELEM_W-1:0] read_value;
  logic [CNT_W-1:0]  length;

  modport source (output valid, status, read_value, length, input ready);
  modport sink   (input valid, status, read_value, length, output ready);
endinterface

// File: hw/rtl/pidl_cell.sv
`timescale 1ns / 1ps
// pidl_cell: one list entry; loads from its left or right neighbour or the
// new value on insert/delete. depends on pidl_pkg

module pidl_cell
  import pidl_pkg::*;
(
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  cell_idx_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [ELEM_W-1:0] left_i,
  input  logic [ELEM_W-1:0] right_i,
  output logic [ELEM_W-1:0] data_o
);

  logic [ELEM_W-1:0] data_q, data_d;
  logic [POS_W-1:0]  idx;
  logic              load;

  assign idx = POS_W'(cell_idx_i);

  always_comb begin
    load   = 1'b0;
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (idx > ctrl_i.pos) begin
        load   = 1'b1;
        data_d = left_i;
      end else if (idx == ctrl_i.pos) begin
        load   = 1'b1;
        data_d = ctrl_i.value;
      end
    end else if (ctrl_i.del) begin
      if (idx >= ctrl_i.pos) begin
        load   = 1'b1;
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// File: hw/rtl/positional_insert_delete_list.sv
`timescale 1ns / 1ps
// positional_insert_delete_list: ordered list held in a row of shifting cells
// depends on pidl_pkg, pidl_req_if, pidl_rsp_if, pidl_cell
//
//  channel  dir  payload                              transfer when
//  req      in   action, position, write_value        req.valid & req.ready
//  rsp      out  status, read_value, length           rsp.valid & rsp.ready
//  cfg      in   cfg_wdata_i (capacity)               cfg_we_i
//
// one operation per cycle: every cell shifts in the same cycle, the read is a
// single mux over the row. the result is registered and shows in the cycle
// after the request transfer. a request is taken while the result register
// is empty or being drained; a stalled result holds the request side.
// reset empties the list and sets capacity to the store depth.

module positional_insert_delete_list
  import pidl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  pidl_req_if.sink         req,
  pidl_rsp_if.source       rsp
);

  logic [CNT_W-1:0]  cap_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  limit;
  logic              fire;
  action_e           act;
  status_e           status_d;
  logic [ELEM_W-1:0] rd_d;
  cell_ctrl_t        ctrl;

  logic              rsp_valid_q;
  status_e           status_q;
  logic [ELEM_W-1:0] rd_q;
  logic [CNT_W-1:0]  len_q;

  logic [ELEM_W-1:0] cell_data [DEPTH];
  logic [ELEM_W-1:0] cell_left [DEPTH];
  logic [ELEM_W-1:0] cell_right [DEPTH];

  assign req.ready = !rsp_valid_q || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign act       = action_e'(req.action);
  assign limit     = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;

  always_comb begin
    status_d   = ST_OK;
    rd_d       = '0;
    count_d    = count_q;
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.pos   = req.position;
    ctrl.value = req.write_value;
    case (act)
      ACT_INSERT: begin
        if (count_q >= limit) begin
          status_d = ST_FULL;
        end else if (POS_W'(req.position) > POS_W'(count_q)) begin
          status_d = ST_BADPOS;
        end else begin
          ctrl.ins = fire;
          count_d  = count_q + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (POS_W'(req.position) >= POS_W'(count_q)) begin
          status_d = ST_BADPOS;
        end else begin
          ctrl.del = fire;
          count_d  = count_q - CNT_W'(1);
        end
      end
      ACT_READ: begin
        if (POS_W'(req.position) >= POS_W'(count_q)) begin
          status_d = ST_BADPOS;
        end else begin
          rd_d = cell_data[req.position[IDX_W-1:0]];
        end
      end
      ACT_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_left[i] = req.write_value;
    end else begin : g_inner_l
      assign cell_left[i] = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign cell_right[i] = cell_data[i];
    end else begin : g_inner_r
      assign cell_right[i] = cell_data[i+1];
    end

    pidl_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(i)),
      .ctrl_i     (ctrl),
      .left_i     (cell_left[i]),
      .right_i    (cell_right[i]),
      .data_o     (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CNT_W'(DEPTH);
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (fire) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      rd_q     <= rd_d;
      len_q    <= count_d;
    end
  end

  assign rsp.valid      = rsp_valid_q;
  assign rsp.status     = status_q;
  assign rsp.read_value = rd_q;
  assign rsp.length     = len_q;

endmodule

// File: bench/tb_positional_insert_delete_list.sv
`timescale 1ns / 1ps
// tb_positional_insert_delete_list: self-checking bench for the positional list,
// a directed table then random operation phases under varied capacity and flow control
// depends on pidl_pkg, pidl_req_if, pidl_rsp_if and positional_insert_delete_list

module tb_positional_insert_delete_list;
  import pidl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned N_DIR       = 27;
  localparam int unsigned N_PHASE     = 8;

  typedef struct packed {
    status_e           status;
    logic [ELEM_W-1:0] read_value;
    logic [CNT_W-1:0]  length;
  } list_result_t;

  typedef enum logic { ROW_OP, ROW_CFG } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    action_e           act;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] val;
    logic              pinned;
    list_result_t      fixed;
  } dir_row_t;

  typedef struct packed {
    logic [CNT_W-1:0] cap;
    int unsigned      src_idle;
    int unsigned      sink_stall;
    int unsigned      n_ops;
    logic             hold;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  pidl_req_if req_if ();
  pidl_rsp_if rsp_if ();

  positional_insert_delete_list i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_if),
    .rsp         (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // shadow list
  logic [ELEM_W-1:0] shadow_entries [DEPTH];
  int unsigned       shadow_len;
  logic [CNT_W-1:0]  shadow_cap;

  list_result_t pending_results [$];

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_asks;
  int unsigned mismatches;
  int unsigned n_sent;
  int unsigned n_results;
  int unsigned n_caps;
  int unsigned n_status [4];
  int unsigned cycle_cnt;

  dir_row_t dir_tab [0:N_DIR-1] = '{
    '{ROW_OP,  ACT_READ,   5'd0,  32'h0,        1'b1, '{ST_BADPOS, 32'h0, 5'd0}},
    '{ROW_OP,  ACT_DELETE, 5'd0,  32'h0,        1'b1, '{ST_EMPTY,  32'h0, 5'd0}},
    '{ROW_OP,  ACT_INSERT, 5'd1,  32'h5A5A5A5A, 1'b1, '{ST_BADPOS, 32'h0, 5'd0}},
    '{ROW_OP,  ACT_INSERT, 5'd0,  32'hFFFFFFFF, 1'b1, '{ST_OK,     32'h0, 5'd1}},
    '{ROW_OP,  ACT_INSERT, 5'd0,  32'h0,        1'b1, '{ST_OK,     32'h0, 5'd2}},
    '{ROW_OP,  ACT_INSERT, 5'd2,  32'hA5A5A5A5, 1'b1, '{ST_OK,     32'h0, 5'd3}},
    '{ROW_OP,  ACT_READ,   5'd1,  32'h0,        1'b1, '{ST_OK, 32'hFFFFFFFF, 5'd3}},
    '{ROW_OP,  ACT_READ,   5'd0,  32'hFFFFFFFF, 1'b1, '{ST_OK,     32'h0, 5'd3}},
    '{ROW_OP,  ACT_READ,   5'd3,  32'h0,        1'b1, '{ST_BADPOS, 32'h0, 5'd3}},
    '{ROW_OP,  ACT_READ,   5'd31, 32'h0,        1'b1, '{ST_BADPOS, 32'h0, 5'd3}},
    '{ROW_OP,  ACT_INSERT, 5'd31, 32'h5A5A5A5A, 1'b1, '{ST_BADPOS, 32'h0, 5'd3}},
    '{ROW_OP,  ACT_DELETE, 5'd3,  32'h0,        1'b1, '{ST_BADPOS, 32'h0, 5'd3}},
    '{ROW_OP,  ACT_DELETE, 5'd31, 32'h0,        1'b1, '{ST_BADPOS, 32'h0, 5'd3}},
    '{ROW_OP,  ACT_DELETE, 5'd1,  32'hFFFFFFFF, 1'b0, '0},
    '{ROW_OP,  ACT_READ,   5'd1,  32'h0,        1'b0, '0},
    '{ROW_OP,  ACT_INSERT, 5'd1,  32'h13579BDF, 1'b0, '0},
    '{ROW_OP,  ACT_CLEAR,  5'd0,  32'hFFFFFFFF, 1'b1, '{ST_OK,     32'h0, 5'd0}},
    '{ROW_OP,  ACT_READ,   5'd0,  32'h0,        1'b1, '{ST_BADPOS, 32'h0, 5'd0}},
    '{ROW_CFG, ACT_INSERT, 5'd0,  32'd0,        1'b0, '0},
    '{ROW_OP,  ACT_INSERT, 5'd0,  32'h2468ACE0, 1'b1, '{ST_FULL,   32'h0, 5'd0}},
    '{ROW_CFG, ACT_INSERT, 5'd0,  32'd1,        1'b0, '0},
    '{ROW_OP,  ACT_INSERT, 5'd0,  32'h0F0F0F0F, 1'b1, '{ST_OK,     32'h0, 5'd1}},
    '{ROW_OP,  ACT_INSERT, 5'd5,  32'h0,        1'b1, '{ST_FULL,   32'h0, 5'd1}},
    '{ROW_CFG, ACT_INSERT, 5'd0,  32'd31,       1'b0, '0},
    '{ROW_OP,  ACT_INSERT, 5'd1,  32'hF0F0F0F0, 1'b0, '0},
    '{ROW_OP,  ACT_DELETE, 5'd0,  32'h0,        1'b0, '0},
    '{ROW_CFG, ACT_INSERT, 5'd0,  32'd16,       1'b0, '0}
  };

  phase_t phase_tab [0:N_PHASE-1] = '{
    '{5'd16, 0,  0,  70, 1'b0},
    '{5'd31, 80, 0,  60, 1'b0},
    '{5'd4,  0,  80, 60, 1'b0},
    '{5'd16, 22, 22, 70, 1'b0},
    '{5'd0,  22, 22, 20, 1'b0},
    '{5'd1,  0,  0,  40, 1'b0},
    '{5'd16, 0,  0,  60, 1'b1},
    '{5'd9,  80, 80, 70, 1'b0}
  };

  function automatic list_result_t apply_op(action_e act, logic [POS_W-1:0] pos,
                                            logic [ELEM_W-1:0] val);
    list_result_t r;
    int unsigned  lim;
    int unsigned  p;
    r   = '{ST_OK, '0, '0};
    lim = (32'(shadow_cap) > DEPTH) ? DEPTH : 32'(shadow_cap);
    p   = 32'(pos);
    case (act)
      ACT_INSERT: begin
        if (shadow_len >= lim) r.status = ST_FULL;
        else if (p > shadow_len) r.status = ST_BADPOS;
        else begin
          for (int i = int'(shadow_len); i > int'(p); i--)
            shadow_entries[IDX_W'(i)] = shadow_entries[IDX_W'(i-1)];
          shadow_entries[IDX_W'(p)] = val;
          shadow_len++;
        end
      end
      ACT_DELETE: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else if (p >= shadow_len) r.status = ST_BADPOS;
        else begin
          for (int i = int'(p); i + 1 < int'(shadow_len); i++)
            shadow_entries[IDX_W'(i)] = shadow_entries[IDX_W'(i+1)];
          shadow_len--;
        end
      end
      ACT_READ: begin
        if (p >= shadow_len) r.status = ST_BADPOS;
        else r.read_value = shadow_entries[IDX_W'(p)];
      end
      default: shadow_len = 0;
    endcase
    r.length = shadow_len[CNT_W-1:0];
    return r;
  endfunction

  // mostly well-formed positions so the list fills and empties
  function automatic void pick_op(output action_e act, output logic [POS_W-1:0] pos,
                                  output logic [ELEM_W-1:0] val);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) act = ACT_INSERT;
    else if (r < 70) act = ACT_DELETE;
    else if (r < 96) act = ACT_READ;
    else act = ACT_CLEAR;
    if ($urandom_range(99) < 15) pos = POS_W'($urandom_range(31, 0));
    else if (act == ACT_INSERT) pos = POS_W'($urandom_range(shadow_len, 0));
    else pos = (shadow_len > 0) ? POS_W'($urandom_range(shadow_len - 1, 0)) : '0;
    r = $urandom_range(9);
    if (r == 0) val = '1;
    else if (r == 1) val = '0;
    else val = $urandom();
  endfunction

  task automatic send_op(input action_e act, input logic [POS_W-1:0] pos,
                         input logic [ELEM_W-1:0] val, input logic pinned,
                         input list_result_t fixed);
    list_result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.position    <= pos;
    req_if.write_value <= val;
    do @(posedge clk_i); while (!req_if.ready);
    r = apply_op(act, pos, val);
    pending_results.push_back(pinned ? fixed : r);
    n_sent++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    shadow_cap  = cap;
    n_caps++;
  endtask

  initial begin : stimulus
    action_e           act;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] val;
    req_if.valid       <= 1'b0;
    req_if.action      <= ACT_INSERT;
    req_if.position    <= '0;
    req_if.write_value <= '0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    shadow_len     = 0;
    shadow_cap     = 5'd16;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_asks      = 0;
    n_sent         = 0;
    n_caps         = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) set_capacity(dir_tab[i].val[CNT_W-1:0]);
      else send_op(dir_tab[i].act, dir_tab[i].pos, dir_tab[i].val, dir_tab[i].pinned,
                   dir_tab[i].fixed);
    end

    foreach (phase_tab[k]) begin
      set_capacity(phase_tab[k].cap);
      src_idle_pct   = phase_tab[k].src_idle;
      sink_stall_pct = phase_tab[k].sink_stall;
      if (phase_tab[k].hold) hold_asks++;
      for (int n = 0; n < phase_tab[k].n_ops; n++) begin
        pick_op(act, pos, val);
        send_op(act, pos, val, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("covered %0d operations over %0d capacity settings, long result stall included",
             n_sent, n_caps);
    $display("results: %0d ok, %0d full, %0d empty, %0d bad position",
             n_status[ST_OK], n_status[ST_FULL], n_status[ST_EMPTY], n_status[ST_BADPOS]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_positional_insert_delete_list: clean");
    end else begin
      $display("tb_positional_insert_delete_list: errors");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        rsp_if.ready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // result transfer checked against the oldest expectation
  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_results++;
      n_status[rsp_if.status]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: status %0d read_value %h length %0d", $time,
                 rsp_if.status, rsp_if.read_value, rsp_if.length);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status) begin
          mismatches++;
          $display("%0t status: expected %0d actual %0d", $time, want.status, rsp_if.status);
        end
        if (rsp_if.read_value !== want.read_value) begin
          mismatches++;
          $display("%0t read_value: expected %h actual %h", $time, want.read_value,
                   rsp_if.read_value);
        end
        if (rsp_if.length !== want.length) begin
          mismatches++;
          $display("%0t length: expected %0d actual %0d", $time, want.length, rsp_if.length);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("tb_positional_insert_delete_list: errors");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    n_results  = 0;
    cycle_cnt  = 0;
    foreach (n_status[i]) n_status[i] = 0;
  end

endmodule
